>>> sv/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros for the text console writer. They expand to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw assertion failed");
// next-cycle implication, disabled in reset
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw assertion failed");
`else
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> sv/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath types of the console
// writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int TOTAL_CELLS = COLUMNS * ROWS;

   // field widths
   localparam int CELL_W     = 11;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // tab stops
   localparam int TAB_STOP = 8;
   localparam int TAB_LOG  = $clog2(TAB_STOP);
   localparam int TAB_W    = TAB_LOG + 1;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CELL = 1'b1;
   localparam logic [ATTR_W-1:0]    ATTR_RESET     = 8'd7;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CURSOR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_PRINT,
      CLASS_NEWLINE,
      CLASS_TAB,
      CLASS_BACKSPACE
   } char_class_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INIT,
      CUR_LOCATE,
      CUR_INC,
      CUR_DEC,
      CUR_NEWLINE,
      CUR_SCROLL
   } cur_op_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_item;
      cur_op_type cur_op;
      logic       emit;
      kind_type   kind;
      logic       blank;
      logic       last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                 out_free;
      logic                 past_end;
      logic                 col_wide;
      logic                 at_origin;
      char_class_type       char_class;
      logic [TAB_W-1:0]     tab_span;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> sv/tcw_if.sv
// ---------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the console writer: character input, result
// output and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              string_end;
   modport source (output valid, char_code, string_end, input ready);
   modport sink   (input valid, char_code, string_end, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CELL_W-1:0] cell_res;
   logic [CHAR_W-1:0] char_out;
   logic [ATTR_W-1:0] attr_out;
   logic              last;
   logic              string_done;
   modport source (output valid, kind, cell_res, char_out, attr_out, last, string_done,
                   input ready);
   modport sink   (input valid, kind, cell_res, char_out, attr_out, last, string_done,
                   output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/text_console_writer.sv
// The first result of a character is registered after the sequencer has
// dispatched it; after that one result per cycle while rsp is not stalled.
// A new character is taken only once the last result of the previous one
// has been issued; the very first item after reset first locates the start column.
// Reset (synchronous, active high) clears the sequencer, output valid,
// attribute (to 7) and start cell (to 0); the next item takes start_cell.
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_writer
// Teletype-style writer for a COLUMNS x ROWS text screen: turns each input
// character into cell writes, scroll commands and cursor updates.
// ---------------------------------------------------------------------------

module text_console_writer (
   input  wire        clock,
   input  wire        reset,
   tcw_req_if.sink    req_chan,
   tcw_rsp_if.source  rsp_chan,
   tcw_csr_if.sink    csr_chan
);
   import tcw_pkg::*;

   `include "text_console_writer_assert.svh"

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   // Register writes are always taken; the caller only writes while idle, which the block itself does not enforce.
   assign csr_chan.ready = 1'b1;

   // Sequencer: ready only between characters, one result per cycle
   // when the output register is free.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Datapath: cursor cell/column, registers and the result register
   // that parts the sequencer from a stalled rsp side.
   tcw_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_char_code   (req_chan.char_code),
      .req_string_end  (req_chan.string_end),
      .csr_valid       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_cell_res    (rsp_chan.cell_res),
      .rsp_char_out    (rsp_chan.char_out),
      .rsp_attr_out    (rsp_chan.attr_out),
      .rsp_last        (rsp_chan.last),
      .rsp_string_done (rsp_chan.string_done)
   );

   // A new result is only loaded when the old one has gone or is leaving.
   `TCW_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.out_free)
   // Cursor updates always land on the screen.
   `TCW_ASSERT_NOW(a_cursor_on_screen, clock, reset, rsp_chan.valid && (rsp_chan.kind == KIND_CURSOR), rsp_chan.cell_res < CELL_W'(TOTAL_CELLS))
   // A taken character blocks the input until its results are done.
   `TCW_ASSERT_NEXT(a_one_item, clock, reset, req_chan.valid && req_ready, !req_ready)
   // string_done only rides on the closing result.
   `TCW_ASSERT_NOW(a_done_on_last, clock, reset, rsp_chan.valid && rsp_chan.string_done, rsp_chan.last)

endmodule

`default_nettype wire

>>> sv/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: decides per character which cell
// writes, scrolls and cursor updates go out, one per cycle when the output is free.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  tcw_pkg::dp_sts_type  sts,
   output tcw_pkg::dp_cmd_type  cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_DISPATCH,
      ST_WRITE,
      ST_CHECK,
      ST_CURSOR
   } state_type;

   state_type            state_ff, state_in;
   char_class_type       mode_ff, mode_in;
   logic                 final_ff, final_in;     // closing cursor update pending
   logic [TAB_W-1:0]     tab_left_ff, tab_left_in;
   logic                 started_ff, started_in;
   logic                 cursor_go;
   logic                 done_now;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      final_in    = final_ff;
      tab_left_in = tab_left_ff;
      started_in  = started_ff;
      cmd         = '0;
      cmd.cur_op  = CUR_HOLD;
      cmd.kind    = KIND_WRITE;
      cursor_go   = 1'b0;
      req_ready   = 1'b0;
      done_now    = (mode_ff == CLASS_PRINT) || (mode_ff == CLASS_NEWLINE) || final_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               final_in      = 1'b0;
               if (!started_ff) begin
                  cmd.cur_op = CUR_INIT;
                  started_in = 1'b1;
                  state_in   = ST_LOCATE;
               end else begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_LOCATE: begin
            if (sts.col_wide) begin
               cmd.cur_op = CUR_LOCATE;
            end else begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            mode_in = sts.char_class;
            unique case (sts.char_class)
               CLASS_NEWLINE: begin
                  cmd.cur_op = CUR_NEWLINE;
                  state_in   = ST_CHECK;
               end
               CLASS_TAB: begin
                  tab_left_in = sts.tab_span;
                  state_in    = ST_WRITE;
               end
               CLASS_BACKSPACE: begin
                  if (!sts.at_origin) begin
                     cmd.cur_op = CUR_DEC;
                  end
                  state_in = ST_WRITE;
               end
               default: begin
                  state_in = ST_WRITE;
               end
            endcase
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = KIND_WRITE;
               cmd.blank  = (mode_ff != CLASS_PRINT);
               cmd.cur_op = CUR_INC;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.out_free) begin
               if (sts.past_end) begin
                  cmd.emit   = 1'b1;
                  cmd.kind   = KIND_SCROLL;
                  cmd.cur_op = CUR_SCROLL;
                  state_in   = ST_CURSOR;
               end else begin
                  cursor_go = 1'b1;
               end
            end
         end
         ST_CURSOR: begin
            if (sts.out_free) begin
               cursor_go = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // cursor update and what follows it
      if (cursor_go) begin
         cmd.emit = 1'b1;
         cmd.kind = KIND_CURSOR;
         cmd.last = done_now;
         if (done_now) begin
            state_in = ST_IDLE;
         end else if (mode_ff == CLASS_TAB) begin
            if (tab_left_ff > TAB_W'(1)) begin
               tab_left_in = tab_left_ff - TAB_W'(1);
               state_in    = ST_WRITE;
            end else begin
               final_in = 1'b1;
               state_in = ST_CHECK;
            end
         end else begin
            // backspace: return to the blanked cell
            cmd.cur_op = CUR_DEC;
            final_in   = 1'b1;
            state_in   = ST_CHECK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= CLASS_PRINT;
         final_ff    <= 1'b0;
         tab_left_ff <= '0;
         started_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         final_ff    <= final_in;
         tab_left_ff <= tab_left_in;
         started_ff  <= started_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/tcw_dp.sv
// ---------------------------------------------------------------------------
// tcw_dp
// Datapath of the console writer: registers, cursor cell and column,
// character latch and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_dp (
   input  wire                               clock,
   input  wire                               reset,
   input  tcw_pkg::dp_cmd_type               cmd,
   output tcw_pkg::dp_sts_type               sts,
   input  wire [tcw_pkg::CHAR_W-1:0]         req_char_code,
   input  wire                               req_string_end,
   input  wire                               csr_valid,
   input  wire [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [tcw_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [tcw_pkg::KIND_W-1:0]        rsp_kind,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_res,
   output logic [tcw_pkg::CHAR_W-1:0]        rsp_char_out,
   output logic [tcw_pkg::ATTR_W-1:0]        rsp_attr_out,
   output logic                              rsp_last,
   output logic                              rsp_string_done
);
   import tcw_pkg::*;

   localparam logic [CELL_W-1:0] CELL_COLUMNS = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] CELL_LAST    = CELL_W'(TOTAL_CELLS - 1);
   localparam logic [CELL_W-1:0] CELL_BOTTOM  = CELL_W'(TOTAL_CELLS - COLUMNS);
   localparam logic [CELL_W-1:0] CELL_TOTAL   = CELL_W'(TOTAL_CELLS);

   logic [ATTR_W-1:0]  attr_ff;
   logic [CELL_W-1:0]  start_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               end_ff;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [CELL_W-1:0]  col_ff, col_in;    // wide while the start cell is located
   logic [CELL_W-1:0]  start_sat;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [CELL_W-1:0]  cell_res_ff;
   logic [CHAR_W-1:0]  char_out_ff;
   logic [ATTR_W-1:0]  attr_out_ff;
   logic               last_ff;
   logic               done_ff;

   assign start_sat = (start_ff >= CELL_TOTAL) ? CELL_LAST : start_ff;

   // status
   always_comb begin
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.past_end  = (cell_ff >= CELL_TOTAL);
      sts.col_wide  = (col_ff >= CELL_COLUMNS);
      sts.at_origin = (cell_ff == '0);
      sts.tab_span  = TAB_W'(TAB_STOP) - TAB_W'(cell_ff[TAB_LOG-1:0]);
      if (char_ff == CHAR_NEWLINE) begin
         sts.char_class = CLASS_NEWLINE;
      end else if (char_ff == CHAR_TAB) begin
         sts.char_class = CLASS_TAB;
      end else if (char_ff == CHAR_BACKSPACE) begin
         sts.char_class = CLASS_BACKSPACE;
      end else begin
         sts.char_class = CLASS_PRINT;
      end
   end

   // cursor update
   always_comb begin
      cell_in = cell_ff;
      col_in  = col_ff;
      unique case (cmd.cur_op)
         CUR_INIT: begin
            cell_in = start_sat;
            col_in  = start_sat;
         end
         CUR_LOCATE: begin
            col_in = col_ff - CELL_COLUMNS;
         end
         CUR_INC: begin
            cell_in = cell_ff + CELL_W'(1);
            col_in  = (col_ff == CELL_COLUMNS - CELL_W'(1)) ? '0 : col_ff + CELL_W'(1);
         end
         CUR_DEC: begin
            cell_in = cell_ff - CELL_W'(1);
            col_in  = (col_ff == '0) ? CELL_COLUMNS - CELL_W'(1) : col_ff - CELL_W'(1);
         end
         CUR_NEWLINE: begin
            cell_in = cell_ff - col_ff + CELL_COLUMNS;
            col_in  = '0;
         end
         CUR_SCROLL: begin
            cell_in = CELL_BOTTOM;
            col_in  = '0;
         end
         default: begin
            cell_in = cell_ff;
            col_in  = col_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ATTRIBUTE:  attr_ff  <= csr_data[ATTR_W-1:0];
               CSR_START_CELL: start_ff <= csr_data[CELL_W-1:0];
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      col_ff  <= col_in;
      if (cmd.load_item) begin
         char_ff <= req_char_code;
         end_ff  <= req_string_end;
      end
      if (cmd.emit) begin
         kind_ff     <= cmd.kind;
         last_ff     <= cmd.last;
         done_ff     <= cmd.last & end_ff;
         cell_res_ff <= (cmd.kind == KIND_SCROLL) ? '0 : cell_ff;
         char_out_ff <= (cmd.kind != KIND_WRITE) ? '0 :
                        (cmd.blank ? CHAR_SPACE : char_ff);
         attr_out_ff <= (cmd.kind == KIND_SCROLL) ? '0 : attr_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_cell_res    = cell_res_ff;
   assign rsp_char_out    = char_out_ff;
   assign rsp_attr_out    = attr_out_ff;
   assign rsp_last        = last_ff;
   assign rsp_string_done = done_ff;

endmodule

`default_nettype wire
